FILE: design/lagr_pkg.sv
package lagr_pkg;

  localparam int unsigned MaxPointsDefault = 16;
  localparam int unsigned ValW = 31;
  localparam logic [ValW-1:0] ModulusReset = 31'd39551;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOINV = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  // datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DIV_XIN,
    OP_DIV_YIN,
    OP_SET_XRED,
    OP_STORE,
    OP_INIT_I,
    OP_RD_I,
    OP_RD_J,
    OP_DIV_RDX,
    OP_DIV_RDY,
    OP_DIV_PROD,
    OP_DIV_EUC,
    OP_SET_XI,
    OP_SET_TMP,
    OP_MUL_NUM,
    OP_MUL_DEN,
    OP_MUL_QNS,
    OP_MUL_LI,
    OP_MUL_Y,
    OP_SET_NUM,
    OP_SET_DEN,
    OP_EU_INIT,
    OP_SET_QR,
    OP_SET_S,
    OP_SET_ACC,
    OP_INC_I,
    OP_INC_J,
    OP_RES_OK,
    OP_RES_NOINV,
    OP_RES_OVER
  } op_e;

  // datapath status toward the controller
  typedef struct packed {
    logic div_done;
    logic last;
    logic ovf;
    logic q_zero;
    logic j_eq_i;
    logic j_end;
    logic i_end;
    logic nr_zero;
    logic r_gt1;
  } dp_stat_t;

endpackage

FILE: design/lagr_ctrl.sv
module lagr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  lagr_pkg::dp_stat_t stat_i,
  output lagr_pkg::op_e     op_o
);
  import lagr_pkg::*;

  localparam logic [5:0] S_IDLE = 6'd0;
  localparam logic [5:0] S_DX   = 6'd1;
  localparam logic [5:0] S_DXW  = 6'd2;
  localparam logic [5:0] S_DY   = 6'd3;
  localparam logic [5:0] S_DYW  = 6'd4;
  localparam logic [5:0] S_EV   = 6'd5;
  localparam logic [5:0] S_RI   = 6'd6;
  localparam logic [5:0] S_DXI  = 6'd7;
  localparam logic [5:0] S_DXIW = 6'd8;
  localparam logic [5:0] S_JCHK = 6'd9;
  localparam logic [5:0] S_RJ   = 6'd10;
  localparam logic [5:0] S_DXJ  = 6'd11;
  localparam logic [5:0] S_DXJW = 6'd12;
  localparam logic [5:0] S_MN   = 6'd13;
  localparam logic [5:0] S_PN   = 6'd14;
  localparam logic [5:0] S_PNW  = 6'd15;
  localparam logic [5:0] S_MD   = 6'd16;
  localparam logic [5:0] S_PD   = 6'd17;
  localparam logic [5:0] S_PDW  = 6'd18;
  localparam logic [5:0] S_JNX  = 6'd19;
  localparam logic [5:0] S_EC   = 6'd20;
  localparam logic [5:0] S_EW   = 6'd21;
  localparam logic [5:0] S_MQ   = 6'd22;
  localparam logic [5:0] S_PQ   = 6'd23;
  localparam logic [5:0] S_PQW  = 6'd24;
  localparam logic [5:0] S_PL   = 6'd25;
  localparam logic [5:0] S_PLW  = 6'd26;
  localparam logic [5:0] S_RY   = 6'd27;
  localparam logic [5:0] S_DYI  = 6'd28;
  localparam logic [5:0] S_DYIW = 6'd29;
  localparam logic [5:0] S_MY   = 6'd30;
  localparam logic [5:0] S_PY   = 6'd31;
  localparam logic [5:0] S_PYW  = 6'd32;
  localparam logic [5:0] S_INX  = 6'd33;

  logic [5:0] state_q, state_d;

  assign busy_o = (state_q != S_IDLE);

  // sequencer: one micro-op per cycle, waits on the serial divider
  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_IDLE: if (start_i) begin op_o = OP_CAPTURE; state_d = S_DX; end
      S_DX:   begin op_o = OP_DIV_XIN; state_d = S_DXW; end
      S_DXW:  if (stat_i.div_done) begin op_o = OP_SET_XRED; state_d = S_DY; end
      S_DY:   begin op_o = OP_DIV_YIN; state_d = S_DYW; end
      S_DYW:  if (stat_i.div_done) begin
        op_o    = OP_STORE;
        state_d = stat_i.last ? S_EV : S_IDLE;
      end
      S_EV: begin
        state_d = S_IDLE;
        if (stat_i.ovf) op_o = OP_RES_OVER;
        else if (stat_i.q_zero) op_o = OP_RES_NOINV;
        else begin op_o = OP_INIT_I; state_d = S_RI; end
      end
      S_RI:   begin op_o = OP_RD_I; state_d = S_DXI; end
      S_DXI:  begin op_o = OP_DIV_RDX; state_d = S_DXIW; end
      S_DXIW: if (stat_i.div_done) begin op_o = OP_SET_XI; state_d = S_JCHK; end
      S_JCHK: state_d = stat_i.j_eq_i ? S_JNX : S_RJ;
      S_RJ:   begin op_o = OP_RD_J; state_d = S_DXJ; end
      S_DXJ:  begin op_o = OP_DIV_RDX; state_d = S_DXJW; end
      S_DXJW: if (stat_i.div_done) begin op_o = OP_SET_TMP; state_d = S_MN; end
      S_MN:   begin op_o = OP_MUL_NUM; state_d = S_PN; end
      S_PN:   begin op_o = OP_DIV_PROD; state_d = S_PNW; end
      S_PNW:  if (stat_i.div_done) begin op_o = OP_SET_NUM; state_d = S_MD; end
      S_MD:   begin op_o = OP_MUL_DEN; state_d = S_PD; end
      S_PD:   begin op_o = OP_DIV_PROD; state_d = S_PDW; end
      S_PDW:  if (stat_i.div_done) begin op_o = OP_SET_DEN; state_d = S_JNX; end
      S_JNX: begin
        if (stat_i.j_end) begin op_o = OP_EU_INIT; state_d = S_EC; end
        else begin op_o = OP_INC_J; state_d = S_JCHK; end
      end
      // extended Euclid, coefficients kept mod q
      S_EC: begin
        if (stat_i.nr_zero) begin
          if (stat_i.r_gt1) begin op_o = OP_RES_NOINV; state_d = S_IDLE; end
          else begin op_o = OP_MUL_LI; state_d = S_PL; end
        end else begin
          op_o = OP_DIV_EUC; state_d = S_EW;
        end
      end
      S_EW:   if (stat_i.div_done) begin op_o = OP_SET_QR; state_d = S_MQ; end
      S_MQ:   begin op_o = OP_MUL_QNS; state_d = S_PQ; end
      S_PQ:   begin op_o = OP_DIV_PROD; state_d = S_PQW; end
      S_PQW:  if (stat_i.div_done) begin op_o = OP_SET_S; state_d = S_EC; end
      S_PL:   begin op_o = OP_DIV_PROD; state_d = S_PLW; end
      S_PLW:  if (stat_i.div_done) begin op_o = OP_SET_NUM; state_d = S_RY; end
      S_RY:   begin op_o = OP_RD_I; state_d = S_DYI; end
      S_DYI:  begin op_o = OP_DIV_RDY; state_d = S_DYIW; end
      S_DYIW: if (stat_i.div_done) begin op_o = OP_SET_TMP; state_d = S_MY; end
      S_MY:   begin op_o = OP_MUL_Y; state_d = S_PY; end
      S_PY:   begin op_o = OP_DIV_PROD; state_d = S_PYW; end
      S_PYW:  if (stat_i.div_done) begin op_o = OP_SET_ACC; state_d = S_INX; end
      S_INX: begin
        if (stat_i.i_end) begin op_o = OP_RES_OK; state_d = S_IDLE; end
        else begin op_o = OP_INC_I; state_d = S_RI; end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

FILE: design/lagr_dp.sv
module lagr_dp #(
  parameter int unsigned MAX_POINTS = lagr_pkg::MaxPointsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lagr_pkg::op_e              op_i,
  output lagr_pkg::dp_stat_t         stat_o,
  input  logic [lagr_pkg::ValW-1:0]  x_coord_i,
  input  logic [lagr_pkg::ValW-1:0]  y_value_i,
  input  logic                       last_point_i,
  input  logic                       cfg_we_i,
  input  logic [lagr_pkg::ValW-1:0]  cfg_modulus_i,
  output logic                       res_valid_o,
  output logic [lagr_pkg::ValW-1:0]  secret_value_o,
  output logic [1:0]                 status_o
);
  import lagr_pkg::*;

  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned PW = 2 * ValW;

  logic [ValW-1:0] mod_q;
  logic [ValW-1:0] xin_q, yin_q, xred_q;
  logic            last_q, ovf_q;
  logic [CW-1:0]   cnt_q;
  logic [IW-1:0]   i_q, j_q;
  logic [PW-1:0]   mem_q [MAX_POINTS];
  logic [PW-1:0]   rd_q;
  logic [ValW-1:0] xi_q, num_q, den_q, tmp_q, acc_q;
  logic [ValW-1:0] r_q, nr_q, s_q, ns_q, quo_q;
  logic [PW-1:0]   prod_q;
  logic            res_valid_q;
  logic [ValW-1:0] secret_q;
  logic [1:0]      status_q;

  // serial restoring divider: one dividend bit per cycle
  logic [PW-1:0]   dvd_q;
  logic [ValW-1:0] dvs_q, rem_q, dquo_q;
  logic [6:0]      dcnt_q;
  logic            dbusy_q, ddone_q;
  logic [ValW:0]   dtrial;
  logic            dge;

  logic            q_zero, full;
  logic [ValW:0]   diff_wrap, sub_wrap, acc_sum;
  logic [ValW-1:0] mul_a, mul_b;

  assign q_zero = (mod_q == '0);
  assign full   = (cnt_q == CW'(MAX_POINTS));

  assign dtrial = {rem_q, dvd_q[PW-1]};
  assign dge    = (dtrial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      ddone_q <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      ddone_q <= 1'b0;
      if (op_i == OP_DIV_XIN || op_i == OP_DIV_YIN || op_i == OP_DIV_RDX ||
          op_i == OP_DIV_RDY || op_i == OP_DIV_EUC) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= 7'(ValW);
      end else if (op_i == OP_DIV_PROD) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= 7'(PW);
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q - 7'd1;
        if (dcnt_q == 7'd1) begin
          dbusy_q <= 1'b0;
          ddone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_DIV_XIN: begin dvd_q <= {xin_q, ValW'(0)}; dvs_q <= mod_q; end
      OP_DIV_YIN: begin dvd_q <= {yin_q, ValW'(0)}; dvs_q <= mod_q; end
      OP_DIV_RDX: begin dvd_q <= {rd_q[PW-1:ValW], ValW'(0)}; dvs_q <= mod_q; end
      OP_DIV_RDY: begin dvd_q <= {rd_q[ValW-1:0], ValW'(0)}; dvs_q <= mod_q; end
      OP_DIV_EUC: begin dvd_q <= {r_q, ValW'(0)}; dvs_q <= nr_q; end
      OP_DIV_PROD: begin dvd_q <= prod_q; dvs_q <= mod_q; end
      default: ;
    endcase
    if (op_i == OP_DIV_XIN || op_i == OP_DIV_YIN || op_i == OP_DIV_RDX ||
        op_i == OP_DIV_RDY || op_i == OP_DIV_EUC || op_i == OP_DIV_PROD) begin
      rem_q  <= '0;
      dquo_q <= '0;
    end else if (dbusy_q) begin
      dvd_q  <= {dvd_q[PW-2:0], 1'b0};
      rem_q  <= dge ? ValW'(dtrial - {1'b0, dvs_q}) : dtrial[ValW-1:0];
      dquo_q <= {dquo_q[ValW-2:0], dge};
    end
  end

  // modular helpers
  assign diff_wrap = {1'b0, xi_q} + {1'b0, mod_q} - {1'b0, tmp_q};
  assign sub_wrap  = {1'b0, s_q} + {1'b0, mod_q} - {1'b0, rem_q};
  assign acc_sum   = {1'b0, acc_q} + {1'b0, rem_q};

  // multiplier operand selection
  always_comb begin
    mul_a = num_q;
    mul_b = mod_q - tmp_q;
    case (op_i)
      OP_MUL_DEN: begin
        mul_a = den_q;
        mul_b = (xi_q >= tmp_q) ? (xi_q - tmp_q) : diff_wrap[ValW-1:0];
      end
      OP_MUL_QNS: begin mul_a = quo_q; mul_b = ns_q; end
      OP_MUL_LI:  begin mul_a = num_q; mul_b = s_q; end
      OP_MUL_Y:   begin mul_a = tmp_q; mul_b = num_q; end
      default: ;
    endcase
  end

  // point store
  always_ff @(posedge clk_i) begin
    if (op_i == OP_STORE && !full) begin
      mem_q[cnt_q[IW-1:0]] <= {xred_q, q_zero ? yin_q : rem_q};
    end
    if (op_i == OP_RD_I) rd_q <= mem_q[i_q];
    else if (op_i == OP_RD_J) rd_q <= mem_q[j_q];
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_CAPTURE:  begin xin_q <= x_coord_i; yin_q <= y_value_i; end
      OP_SET_XRED: xred_q <= q_zero ? xin_q : rem_q;
      OP_INIT_I:   acc_q <= '0;
      OP_SET_XI:   begin xi_q <= rem_q; num_q <= ValW'(1); den_q <= ValW'(1); end
      OP_SET_TMP:  tmp_q <= rem_q;
      OP_SET_NUM:  num_q <= rem_q;
      OP_SET_DEN:  den_q <= rem_q;
      OP_EU_INIT:  begin r_q <= mod_q; nr_q <= den_q; s_q <= '0; ns_q <= ValW'(1); end
      OP_SET_QR:   begin quo_q <= dquo_q; r_q <= nr_q; nr_q <= rem_q; end
      OP_SET_S: begin
        s_q  <= ns_q;
        ns_q <= (s_q >= rem_q) ? (s_q - rem_q) : sub_wrap[ValW-1:0];
      end
      OP_SET_ACC:
        acc_q <= (acc_sum >= {1'b0, mod_q}) ? ValW'(acc_sum - {1'b0, mod_q})
                                            : acc_sum[ValW-1:0];
      OP_MUL_NUM, OP_MUL_DEN, OP_MUL_QNS, OP_MUL_LI, OP_MUL_Y:
        prod_q <= PW'(mul_a) * PW'(mul_b);
      default: ;
    endcase
  end

  // control state: config, counters, flags, result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= ModulusReset;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      res_valid_q <= 1'b0;
      secret_q    <= '0;
      status_q    <= ST_OK;
    end else begin
      if (cfg_we_i) mod_q <= cfg_modulus_i;
      res_valid_q <= 1'b0;
      case (op_i)
        OP_CAPTURE: last_q <= last_point_i;
        OP_STORE: begin
          if (full) ovf_q <= 1'b1;
          else cnt_q <= cnt_q + CW'(1);
        end
        OP_INIT_I: i_q <= '0;
        OP_SET_XI: j_q <= '0;
        OP_INC_I:  i_q <= i_q + IW'(1);
        OP_INC_J:  j_q <= j_q + IW'(1);
        OP_RES_OK, OP_RES_NOINV, OP_RES_OVER: begin
          res_valid_q <= 1'b1;
          secret_q    <= (op_i == OP_RES_OK) ? acc_q : '0;
          status_q    <= (op_i == OP_RES_OK) ? ST_OK :
                         (op_i == OP_RES_NOINV) ? ST_NOINV : ST_OVER;
          cnt_q       <= '0;
          ovf_q       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.div_done = ddone_q;
  assign stat_o.last     = last_q;
  assign stat_o.ovf      = ovf_q;
  assign stat_o.q_zero   = q_zero;
  assign stat_o.j_eq_i   = (j_q == i_q);
  assign stat_o.j_end    = ((CW'(j_q) + CW'(1)) == cnt_q);
  assign stat_o.i_end    = ((CW'(i_q) + CW'(1)) == cnt_q);
  assign stat_o.nr_zero  = (nr_q == '0);
  assign stat_o.r_gt1    = (r_q > ValW'(1));

  assign res_valid_o    = res_valid_q;
  assign secret_value_o = secret_q;
  assign status_o       = status_q;

endmodule

FILE: design/lagrange_interpolate_zero_mod_top.sv
// Shamir secret reconstruction: Lagrange interpolation at zero mod q.
// Input: present x_coord_i, y_value_i, last_point_i with start_i; the request
// is taken at a clock edge with start_i high and busy_o low. Each point is
// reduced mod q (two serial reductions) and stored.
// A request with last_point_i closes the set and runs the evaluation; one
// result is then shown on secret_value_o/status_o for a single cycle marked
// by result_valid_o. The receiver cannot stall; it must take it then.
// Evaluation cost is set by the single serial divider (one bit per cycle):
// three divisions per ordered pair of points plus, per point, an extended
// Euclid inverse of up to ~45 steps of two divisions each. Points past
// MAX_POINTS are dropped and the set reports status 2; a missing inverse
// reports status 1. Status 0 is ok.
// Configuration: cfg_valid_i/cfg_ready_o write the modulus (ready always
// high); write it only while the block is idle. Reset sets modulus 39551
// and empties the point set; the point store itself is not cleared.
module lagrange_interpolate_zero_mod_top #(
  parameter int unsigned MAX_POINTS = lagr_pkg::MaxPointsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [lagr_pkg::ValW-1:0] x_coord_i,
  input  logic [lagr_pkg::ValW-1:0] y_value_i,
  input  logic                      last_point_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lagr_pkg::ValW-1:0] cfg_modulus_i,
  output logic                      result_valid_o,
  output logic [lagr_pkg::ValW-1:0] secret_value_o,
  output logic [1:0]                status_o
);
  import lagr_pkg::*;

  op_e      op;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  lagr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .op_o    (op)
  );

  lagr_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .stat_o         (stat),
    .x_coord_i      (x_coord_i),
    .y_value_i      (y_value_i),
    .last_point_i   (last_point_i),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_modulus_i  (cfg_modulus_i),
    .res_valid_o    (result_valid_o),
    .secret_value_o (secret_value_o),
    .status_o       (status_o)
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ST_OK |-> secret_value_o == '0)
    else $error("nonzero value with error status");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (status_o == ST_OK || status_o == ST_NOINV ||
                        status_o == ST_OVER))
    else $error("bad status code");
  a_one_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("request accepted but block not busy");
`endif

endmodule
